FILE: hdl/hcbd_pkg.sv
// Shared types and constants for the chunked HTTP body decoder.
// No dependencies; used by hcbd_front, hcbd_back and the top level.
package hcbd_pkg;

    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_VT    = 8'h0B;
    localparam logic [7:0] C_FF    = 8'h0C;

    // Classified body byte handed from front to back.
    typedef struct packed {
        logic [7:0] raw;
        logic       is_lf;
        logic       is_space;
        logic       is_hex;
        logic [3:0] hex;
    } t_cls;

endpackage

FILE: hdl/hcbd_front.sv
// Front end: accepts body bytes, classifies them, and queues them (2 deep).
// Depends on hcbd_pkg.
module hcbd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_body_valid,
    input  logic [7:0]         i_body_byte,
    output logic               o_body_stall,
    output logic               o_q_valid,
    output hcbd_pkg::t_cls     o_q_item,
    input  logic               i_q_pop
);

    hcbd_pkg::t_cls r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    hcbd_pkg::t_cls w_cls;
    logic           w_push;

    always_comb begin
        w_cls          = '0;
        w_cls.raw      = i_body_byte;
        w_cls.is_lf    = (i_body_byte == hcbd_pkg::C_LF);
        w_cls.is_space = (i_body_byte == hcbd_pkg::C_SPACE) || (i_body_byte == hcbd_pkg::C_TAB)
                      || (i_body_byte == hcbd_pkg::C_CR) || (i_body_byte == hcbd_pkg::C_VT)
                      || (i_body_byte == hcbd_pkg::C_FF);
        if (i_body_byte >= 8'h30 && i_body_byte <= 8'h39) begin
            w_cls.is_hex = 1'b1;
            w_cls.hex    = 4'(i_body_byte - 8'h30);
        end else if (i_body_byte >= 8'h61 && i_body_byte <= 8'h66) begin
            w_cls.is_hex = 1'b1;
            w_cls.hex    = 4'(i_body_byte - 8'h57);
        end else if (i_body_byte >= 8'h41 && i_body_byte <= 8'h46) begin
            w_cls.is_hex = 1'b1;
            w_cls.hex    = 4'(i_body_byte - 8'h37);
        end
    end

    assign o_body_stall = (r_cnt == 2'd2);
    assign w_push       = i_body_valid && !o_body_stall;
    assign o_q_valid    = (r_cnt != 2'd0);
    assign o_q_item     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

FILE: hdl/hcbd_back.sv
// Back end: chunk framing state machine, byte counters and result register.
// Depends on hcbd_pkg.
module hcbd_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_chunked_mode,
    input  logic               i_q_valid,
    input  hcbd_pkg::t_cls     i_q_item,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_data_byte,
    output logic               o_is_payload,
    output logic               o_body_end,
    output logic [31:0]        o_bytes_passed
);

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_SKIPLN = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_TRAIL  = 3'd4;
    localparam logic [2:0] PH_END    = 3'd5;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [2:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_size, n_size;
    logic [COUNT_WIDTH-1:0] r_left, n_left;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_ov;
    logic [7:0]             r_data;
    logic                   r_pay, r_end;
    logic [31:0]            r_shown;

    logic                   w_res, w_pay, w_end, w_pass;
    logic [31:0]            w_shown;
    logic [COUNT_WIDTH-1:0] w_left_dec;

    assign o_q_pop = i_q_valid && (!r_ov || !i_out_stall);

    generate
        if (COUNT_WIDTH > 32) begin : g_wide
            assign w_shown = (|n_cnt[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : n_cnt[31:0];
        end else begin : g_narrow
            assign w_shown = 32'(n_cnt);
        end
    endgenerate

    assign w_left_dec = (r_left != '0) ? r_left - COUNT_WIDTH'(1) : r_left;

    always_comb begin
        n_phase = r_phase;
        n_size  = r_size;
        n_left  = r_left;
        w_res   = 1'b0;
        w_pay   = 1'b0;
        w_end   = 1'b0;
        w_pass  = 1'b0;
        if (!i_chunked_mode) begin
            w_pass = 1'b1;
        end else begin
            unique case (r_phase) inside
                PH_LEAD, PH_DIGITS, PH_SKIPLN: begin
                    if (i_q_item.is_lf) begin
                        if (r_size == '0) begin
                            n_phase = PH_END;
                            w_res   = 1'b1;
                            w_end   = 1'b1;
                        end else begin
                            n_left  = r_size;
                            n_phase = PH_DATA;
                        end
                    end else if (r_phase == PH_LEAD) begin
                        if (!i_q_item.is_space) begin
                            n_size = COUNT_WIDTH'(i_q_item.hex);
                            n_phase = i_q_item.is_hex ? PH_DIGITS : PH_SKIPLN;
                        end
                    end else if (r_phase == PH_DIGITS) begin
                        if (!i_q_item.is_hex) begin
                            n_phase = PH_SKIPLN;
                        end else if (|r_size[COUNT_WIDTH-1:COUNT_WIDTH-4]) begin
                            n_size = CNT_MAX;
                        end else begin
                            n_size = {r_size[COUNT_WIDTH-5:0], i_q_item.hex};
                        end
                    end
                end
                PH_DATA: begin
                    w_pass = 1'b1;
                    n_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_phase = PH_TRAIL;
                    end
                end
                PH_TRAIL: begin
                    if (i_q_item.is_lf) begin
                        n_phase = PH_LEAD;
                        n_size  = '0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (w_pass) begin
            w_res = 1'b1;
            w_pay = 1'b1;
        end
        n_cnt = (w_pass && r_cnt != CNT_MAX) ? r_cnt + COUNT_WIDTH'(1) : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data  <= w_pay ? i_q_item.raw : 8'h00;
            r_pay   <= w_pay;
            r_end   <= w_end;
            r_shown <= w_shown;
        end
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_size  <= '0;
            r_left  <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase <= n_phase;
                r_size  <= n_size;
                r_left  <= n_left;
                r_cnt   <= n_cnt;
                r_ov    <= w_res;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_data_byte    = r_data;
    assign o_is_payload   = r_pay;
    assign o_body_end     = r_end;
    assign o_bytes_passed = r_shown;

endmodule

FILE: hdl/http_chunked_body_decoder.sv
// Top level of the chunked HTTP body decoder: APB registers, front and back.
// Depends on hcbd_pkg, hcbd_front and hcbd_back.
//
// The decoder takes one body byte per clock while o_body_stall is low and
// gives at most one request on the output per byte: a payload byte, or a
// single end-of-body marker when the zero-size chunk line completes. Framing
// bytes give no output. With nothing queued ahead of it, an accepted byte
// waits in the front queue and is then decoded into the back end's result
// register, which drives the output; the sustained rate of one byte per cycle,
// while i_out_stall is low, is set by the framing state update in the back
// end. Registers: chunked_mode at 0x0, expected_total at 0x4; write them only
// while no bytes are in flight.
module http_chunked_body_decoder #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_body_valid,
    output logic        o_body_stall,
    input  logic [7:0]  i_body_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_is_payload,
    output logic        o_body_end,
    output logic [31:0] o_bytes_passed,
    output logic [31:0] o_progress_total
);

    localparam logic [2:0] ADDR_MODE  = 3'h0;
    localparam logic [2:0] ADDR_TOTAL = 3'h4;

    logic           r_mode;
    logic [31:0]    r_total;
    logic           w_wr;
    logic           w_q_valid, w_q_pop;
    hcbd_pkg::t_cls w_q_item;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_total <= '0;
        end else if (w_wr) begin
            if (paddr == ADDR_MODE) begin
                r_mode <= pwdata[0];
            end
            if (paddr == ADDR_TOTAL) begin
                r_total <= pwdata;
            end
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_MODE:  prdata = {31'd0, r_mode};
            ADDR_TOTAL: prdata = r_total;
            default:    prdata = '0;
        endcase
    end

    hcbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_body_valid (i_body_valid),
        .i_body_byte  (i_body_byte),
        .o_body_stall (o_body_stall),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    hcbd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_chunked_mode (r_mode),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_q_pop        (w_q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_byte    (o_data_byte),
        .o_is_payload   (o_is_payload),
        .o_body_end     (o_body_end),
        .o_bytes_passed (o_bytes_passed)
    );

    assign o_progress_total = (r_total != '0) ? r_total : o_bytes_passed;

endmodule
